// ===== hw/rtl/resource_safety_checker_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the resource safety checker
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RESOURCE_SAFETY_CHECKER_ASSERT_SVH
`define RESOURCE_SAFETY_CHECKER_ASSERT_SVH

// General property, sampled on the rising edge of clk.
`define RSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold.
`define RSC_NEVER(lbl, cond, msg) \
	`RSC_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsc_pkg
// Types and codes shared by the resource safety checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rsc_pkg;

	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESOURCE_COUNT = 2'd1;

	localparam logic [1:0] MODE_LOAD_ENTRY = 2'd0;
	localparam logic [1:0] MODE_LOAD_FREE  = 2'd1;
	localparam logic [1:0] MODE_RUN        = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] process_index;
		logic [3:0] resource_index;
		logic [7:0] held_units;
		logic [7:0] max_units;
		logic [7:0] free_units;
	} item_t;

	typedef struct packed {
		logic       is_safe;
		logic [3:0] granted_process;
		logic       last;
	} result_t;

	typedef struct packed {
		logic init;
		logic shift;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_PSEL,
		ST_CHECK,
		ST_ADD,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsc_ram.sv =====
// ----------------------------------------------------------------------------
// rsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rsc_cell.sv =====
// ----------------------------------------------------------------------------
// rsc_cell
// One resource slot of the work ring: free units and running work units.
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_cell
	import rsc_pkg::*;
#(
	parameter int UNIT_BITS = 8,
	parameter int WORK_BITS = 13
) (
	input  wire logic                 clk,
	input  wire cell_ctl_t            ctl,
	input  wire logic                 load,
	input  wire logic [UNIT_BITS-1:0] load_data,
	input  wire logic                 in_use,
	input  wire logic [WORK_BITS-1:0] work_in,
	output logic      [WORK_BITS-1:0] work_out
);

	logic [UNIT_BITS-1:0] free_q;
	logic [WORK_BITS-1:0] work_q;

	always_ff @(posedge clk) begin
		if (load) begin
			free_q <= load_data;
		end
		if (ctl.init) begin
			work_q <= in_use ? WORK_BITS'(free_q) : '0;
		end else if (ctl.shift) begin
			work_q <= work_in;
		end
	end

	assign work_out = work_q;

endmodule

`default_nettype wire

// ===== hw/rtl/resource_safety_checker.sv =====
// ----------------------------------------------------------------------------
// resource_safety_checker
// Banker's safety check over a held/max table, a free vector and a work ring.
// ----------------------------------------------------------------------------
// A load word (mode 0 or 1) is stored when it is accepted. A run word
// copies the free units into a ring of MAX_RESOURCES cells, then scans the
// processes pass after pass: a finished process is skipped, an open one has
// its need tested against the ring and, when granted, its held units added
// to the ring; the table RAM gives one held/max entry per cycle and the ring
// turns one cell per entry. After the scan the block drives one result word
// per cycle on result_valid: the safe order, or one unsafe word. Results
// cannot be held off; busy stays high until the last one has gone out.
// ----------------------------------------------------------------------------
`default_nettype none

module resource_safety_checker
	import rsc_pkg::*;
#(
	parameter int MAX_PROCS     = 16,
	parameter int MAX_RESOURCES = 16,
	parameter int UNIT_BITS     = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  start,
	input  wire item_t                 item,
	output logic                       busy,
	output logic                       result_valid,
	output result_t                    result
);

	localparam int PW    = $clog2(MAX_PROCS);
	localparam int PCW   = $clog2(MAX_PROCS + 1);
	localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
	localparam int RCW   = $clog2(MAX_RESOURCES + 1) + 1;
	localparam int DEPTH = MAX_PROCS * MAX_RESOURCES;
	localparam int AW    = $clog2(DEPTH);
	localparam int WB    = UNIT_BITS + PW + 1;

	state_t state_q, state_d;

	logic [CFG_DATA_W-1:0] pcount_q, rcount_q;
	logic [PCW-1:0]        np;
	logic [RCW-1:0]        nr;

	logic [PCW-1:0]        p_q;
	logic [RW:0]           r_q;
	logic                  fit_q, progress_q, safe_q;
	logic [PCW-1:0]        granted_q, k_q;
	logic [MAX_PROCS-1:0]  flags_q;
	logic [PW-1:0]         order_q [MAX_PROCS];
	logic                  rd_valid_s1;
	logic [RW-1:0]         ridx_s1;

	logic [PW-1:0]         p_idx;
	logic                  issue, last_rd, in_use_s1, fits_now, emit_last;
	logic                  accept, wr_ok;
	logic [AW-1:0]         waddr, raddr;
	logic [2*UNIT_BITS-1:0] rdata;
	logic [UNIT_BITS-1:0]  rd_held, rd_max;
	logic [WB:0]           head_sum;
	logic [WB-1:0]         ring_in;
	logic [WB-1:0]         work [MAX_RESOURCES];
	cell_ctl_t             cell_ctl;

	always_comb begin
		if (pcount_q == '0) begin
			np = PCW'(1);
		end else if (32'(pcount_q) > MAX_PROCS) begin
			np = PCW'(MAX_PROCS);
		end else begin
			np = PCW'(pcount_q);
		end
		if (rcount_q == '0) begin
			nr = RCW'(1);
		end else if (32'(rcount_q) > MAX_RESOURCES) begin
			nr = RCW'(MAX_RESOURCES);
		end else begin
			nr = RCW'(rcount_q);
		end
	end

	assign accept = start && !busy;
	assign wr_ok  = (32'(item.process_index) < MAX_PROCS)
		&& (32'(item.resource_index) < MAX_RESOURCES);
	assign p_idx  = p_q[PW-1:0];
	assign waddr  = AW'(AW'(item.process_index) * AW'(MAX_RESOURCES)
		+ AW'(item.resource_index));
	assign raddr  = AW'(AW'(p_idx) * AW'(MAX_RESOURCES) + AW'(r_q[RW-1:0]));

	rsc_ram #(
		.WIDTH (2 * UNIT_BITS),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (accept && item.mode == MODE_LOAD_ENTRY && wr_ok),
		.waddr (waddr),
		.wdata ({UNIT_BITS'(item.max_units), UNIT_BITS'(item.held_units)}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_held   = rdata[UNIT_BITS-1:0];
	assign rd_max    = rdata[2*UNIT_BITS-1:UNIT_BITS];
	assign issue     = (state_q == ST_CHECK || state_q == ST_ADD)
		&& r_q < (RW+1)'(MAX_RESOURCES);
	assign last_rd   = rd_valid_s1 && ridx_s1 == RW'(MAX_RESOURCES - 1);
	assign in_use_s1 = RCW'(ridx_s1) < nr;
	assign head_sum  = (WB+1)'(work[0]) + (WB+1)'(rd_held);
	assign fits_now  = !(in_use_s1 && (WB+1)'(rd_max) > head_sum);
	assign ring_in   = (state_q == ST_ADD && in_use_s1) ? WB'(head_sum) : work[0];

	assign cell_ctl.init  = (state_q == ST_INIT);
	assign cell_ctl.shift = rd_valid_s1;

	for (genvar i = 0; i < MAX_RESOURCES; i++) begin : g_cell
		rsc_cell #(
			.UNIT_BITS (UNIT_BITS),
			.WORK_BITS (WB)
		) u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.load      (accept && item.mode == MODE_LOAD_FREE
				&& 32'(item.resource_index) == i),
			.load_data (UNIT_BITS'(item.free_units)),
			.in_use    (RCW'(i) < nr),
			.work_in   ((i == MAX_RESOURCES - 1) ? ring_in : work[(i + 1) % MAX_RESOURCES]),
			.work_out  (work[i])
		);
	end

	assign emit_last = !safe_q || k_q == np - PCW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		busy         = 1'b1;
		result_valid = 1'b0;
		result       = '0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start && item.mode == MODE_RUN) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				state_d = ST_PSEL;
			end
			ST_PSEL: begin
				if (p_q == np) begin
					if (granted_q == np || !progress_q) begin
						state_d = ST_EMIT;
					end
				end else if (!flags_q[p_idx]) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (last_rd) begin
					state_d = (fit_q && fits_now) ? ST_ADD : ST_PSEL;
				end
			end
			ST_ADD: begin
				if (last_rd) begin
					state_d = ST_PSEL;
				end
			end
			ST_EMIT: begin
				result_valid           = 1'b1;
				result.is_safe         = safe_q;
				result.granted_process = safe_q ? 4'(order_q[k_q[PW-1:0]]) : 4'd0;
				result.last            = emit_last;
				if (emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q    <= CFG_DATA_W'(1);
			rcount_q    <= CFG_DATA_W'(1);
			p_q         <= '0;
			r_q         <= '0;
			fit_q       <= 1'b0;
			progress_q  <= 1'b0;
			safe_q      <= 1'b0;
			granted_q   <= '0;
			k_q         <= '0;
			flags_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_PROCESS_COUNT) begin
				pcount_q <= cfg_wdata;
			end
			if (cfg_we && cfg_index == REG_RESOURCE_COUNT) begin
				rcount_q <= cfg_wdata;
			end
			rd_valid_s1 <= issue;
			if (issue) begin
				r_q <= r_q + 1'b1;
			end
			case (state_q)
				ST_INIT: begin
					p_q        <= '0;
					progress_q <= 1'b0;
					granted_q  <= '0;
					flags_q    <= '0;
				end
				ST_PSEL: begin
					if (p_q == np) begin
						if (granted_q == np) begin
							safe_q <= 1'b1;
							k_q    <= '0;
						end else if (!progress_q) begin
							safe_q <= 1'b0;
						end else begin
							p_q        <= '0;
							progress_q <= 1'b0;
						end
					end else if (flags_q[p_idx]) begin
						p_q <= p_q + 1'b1;
					end else begin
						r_q   <= '0;
						fit_q <= 1'b1;
					end
				end
				ST_CHECK: begin
					if (rd_valid_s1) begin
						fit_q <= fit_q && fits_now;
					end
					if (last_rd) begin
						if (fit_q && fits_now) begin
							r_q <= '0;
						end else begin
							p_q <= p_q + 1'b1;
						end
					end
				end
				ST_ADD: begin
					if (last_rd) begin
						flags_q[p_idx] <= 1'b1;
						granted_q      <= granted_q + 1'b1;
						progress_q     <= 1'b1;
						p_q            <= p_q + 1'b1;
					end
				end
				ST_EMIT: begin
					k_q <= k_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ridx_s1 <= r_q[RW-1:0];
		end
		if (state_q == ST_ADD && last_rd) begin
			order_q[granted_q[PW-1:0]] <= p_idx;
		end
	end

	`include "resource_safety_checker_assert.svh"

	`RSC_ASSERT(a_strobe_busy, result_valid |-> busy, "result strobe while idle")
	`RSC_ASSERT(a_last_idle, (result_valid && result.last) |=> !busy,
		"busy after last result")
	`RSC_ASSERT(a_unsafe_single, (result_valid && !result.is_safe) |-> result.last,
		"unsafe result not marked last")
	`RSC_NEVER(a_load_quiet, accept && item.mode != MODE_RUN && result_valid,
		"result during a load")

endmodule

`default_nettype wire

// ===== tb/sv/resource_safety_checker_monitor.sv =====
// ----------------------------------------------------------------------------
// resource_safety_checker_monitor
// Watches the register port, the command port and the result port of the
// safety checker. It keeps its own tables and counts and works out the safe
// order or the unsafe word for each run. Result words are compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

module resource_safety_checker_monitor
	import rsc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire item_t                 item,
	input  wire logic                  result_valid,
	input  wire result_t               result,
	output int                         errors,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPROC = 16;
	localparam int NRES  = 16;

	logic [7:0] held_units [NPROC][NRES];
	logic [7:0] max_units [NPROC][NRES];
	logic [7:0] free_units [NRES];
	logic [4:0] proc_count;
	logic [4:0] res_count;
	result_t    order_q[$];

	function automatic int clamp_count(logic [4:0] v, int hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : int'(v);
	endfunction

	function automatic void predict_safe_order();
		int      np;
		int      nr;
		int      work[NRES];
		bit      done[NPROC];
		int      order[NPROC];
		int      granted;
		bit      progress;
		bit      fits;
		result_t w;
		np = clamp_count(proc_count, NPROC);
		nr = clamp_count(res_count, NRES);
		granted = 0;
		for (int r = 0; r < NRES; r++)
			work[r] = (r < nr) ? int'(free_units[r]) : 0;
		for (int p = 0; p < NPROC; p++)
			done[p] = 0;
		while (granted < np) begin
			progress = 0;
			for (int p = 0; p < np; p++) begin
				if (done[p])
					continue;
				fits = 1;
				for (int r = 0; r < nr; r++)
					if (int'(max_units[p][r]) - int'(held_units[p][r]) > work[r])
						fits = 0;
				if (!fits)
					continue;
				for (int r = 0; r < nr; r++)
					work[r] += held_units[p][r];
				order[granted] = p;
				granted++;
				done[p] = 1;
				progress = 1;
			end
			if (!progress)
				break;
		end
		if (granted == np) begin
			for (int k = 0; k < np; k++) begin
				w.is_safe = 1'b1;
				w.granted_process = order[k][3:0];
				w.last = (k + 1 == np);
				order_q.push_back(w);
			end
		end else begin
			w.is_safe = 1'b0;
			w.granted_process = 4'd0;
			w.last = 1'b1;
			order_q.push_back(w);
		end
	endfunction

	assign pending = order_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			proc_count <= 5'd1;
			res_count <= 5'd1;
			errors = 0;
			order_q.delete();
		end else begin
			if (result_valid) begin
				if (order_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word %p", $time, result);
				end else begin
					want = order_q.pop_front();
					if (result.is_safe !== want.is_safe
							|| result.granted_process !== want.granted_process
							|| result.last !== want.last) begin
						errors++;
						$display("%0t: result mismatch, expected %p, actual %p",
							$time, want, result);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_PROCESS_COUNT)
					proc_count <= cfg_wdata;
				else if (cfg_index == REG_RESOURCE_COUNT)
					res_count <= cfg_wdata;
			end
			if (start && !busy) begin
				case (item.mode)
				MODE_LOAD_ENTRY: begin
					held_units[item.process_index][item.resource_index] = item.held_units;
					max_units[item.process_index][item.resource_index] = item.max_units;
				end
				MODE_LOAD_FREE: begin
					free_units[item.resource_index] = item.free_units;
				end
				MODE_RUN: begin
					predict_safe_order();
				end
				default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/resource_safety_checker_test.sv =====
// ----------------------------------------------------------------------------
// resource_safety_checker_test
// Drives loads, runs and register writes into the safety checker with random
// gaps, mostly as well-formed table fills followed by a run, with noise mixed
// in. The monitor predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module resource_safety_checker_test;
	import rsc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int RANDOM_WORDS = 470;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int ITEM_W = $bits(item_t);

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  start;
	item_t                 item;
	logic                  busy;
	logic                  result_valid;
	result_t               result;
	int                    errors;
	int                    pending;
	longint                cycles;
	int                    sent;

	resource_safety_checker i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .start(start), .item(item), .busy(busy),
		.result_valid(result_valid), .result(result)
	);

	resource_safety_checker_monitor i_monitor (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result), .errors(errors),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL resource_safety_checker");
			$finish;
		end
	end

	task automatic send_word(item_t w);
		int gap;
		@(negedge clk);
		start <= 1'b1;
		item <= w;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		sent++;
		gap = ($urandom_range(0, 9) < 5) ? 0
			: ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (4)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_counts(logic [4:0] np, logic [4:0] nr);
		wait_idle();
		write_reg(REG_PROCESS_COUNT, np);
		write_reg(REG_RESOURCE_COUNT, nr);
	endtask

	function automatic item_t random_item();
		return item_t'(ITEM_W'({$urandom, $urandom}));
	endfunction

	function automatic item_t make_entry(int p, int r, int held, int maxu);
		item_t w;
		w = random_item();
		w.mode = MODE_LOAD_ENTRY;
		w.process_index = p[3:0];
		w.resource_index = r[3:0];
		w.held_units = held[7:0];
		w.max_units = maxu[7:0];
		return w;
	endfunction

	function automatic item_t make_free(int r, int units);
		item_t w;
		w = random_item();
		w.mode = MODE_LOAD_FREE;
		w.resource_index = r[3:0];
		w.free_units = units[7:0];
		return w;
	endfunction

	function automatic item_t make_run();
		item_t w;
		w = random_item();
		w.mode = MODE_RUN;
		return w;
	endfunction

	task automatic fill_scenario(int np, int nr);
		int held;
		for (int p = 0; p < np; p++)
			for (int r = 0; r < nr; r++) begin
				held = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
				send_word(make_entry(p, r,
					held, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
					: held + $urandom_range(0, 4)));
			end
		for (int r = 0; r < nr; r++)
			send_word(make_free(r, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, 5)));
		send_word(make_run());
	endtask

	initial begin
		item_t w;
		int    np;
		int    nr;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		start = 1'b0;
		item = '0;
		cycles = 0;
		sent = 0;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < 16; p++)
			for (int r = 0; r < 16; r++)
				send_word(make_entry(p, r, $urandom_range(0, 3), $urandom_range(0, 3)));
		for (int r = 0; r < 16; r++)
			send_word(make_free(r, $urandom_range(0, 255)));

		send_word(make_run());
		send_word(make_entry(0, 0, 255, 0));
		send_word(make_free(0, 0));
		send_word(make_run());
		send_word(make_entry(0, 0, 0, 255));
		send_word(make_run());
		send_word(make_free(0, 255));
		send_word(make_run());
		w = make_run();
		w.mode = MODE_SPARE;
		send_word(w);
		set_counts(5'd2, 5'd2);
		send_word(make_entry(1, 1, 0, 255));
		send_word(make_entry(15, 15, 255, 255));
		send_word(make_free(15, 255));
		send_word(make_run());
		set_counts(5'd0, 5'd0);
		send_word(make_run());
		set_counts(5'd16, 5'd16);
		send_word(make_run());
		set_counts(5'd31, 5'd31);
		send_word(make_free(1, 255));
		send_word(make_run());
		set_counts(5'd17, 5'd1);
		send_word(make_run());
		wait_idle();
		write_reg(REG_SPARE_A, 5'd31);
		write_reg(REG_SPARE_B, 5'd0);
		send_word(make_run());

		while (sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 9))
			0: begin
				np = $urandom_range(0, 31);
				nr = $urandom_range(0, 31);
			end
			1: begin
				np = 16;
				nr = $urandom_range(1, 3);
			end
			default: begin
				np = $urandom_range(1, 4);
				nr = $urandom_range(1, 4);
			end
			endcase
			set_counts(np[4:0], nr[4:0]);
			np = (np == 0) ? 1 : (np > 16) ? 16 : np;
			nr = (nr == 0) ? 1 : (nr > 16) ? 16 : nr;
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					w = random_item();
					send_word(w);
				end
			end
			fill_scenario(np, nr);
			if ($urandom_range(0, 4) == 0)
				send_word(make_run());
		end

		wait_idle();
		repeat (50)
			@(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS resource_safety_checker");
		else
			$display("FAIL resource_safety_checker");
		$finish;
	end

endmodule

`default_nettype wire
